// File: rtl/core/setr_pkg.sv
// Shared constants, types and the cosine table builder for the sonar echo tilt ranger.
`default_nettype none

package setr_pkg;

	// Field and register widths
	localparam int CLK_W      = 28;
	localparam int TILT_W     = 14;
	localparam int FACTOR_W   = 7;
	localparam int TIME_W     = 32;
	localparam int ANGLE_W    = 16;
	localparam int DIST_W     = 12;
	localparam int STATUS_W   = 2;
	localparam int PULSE_W    = 18;   // in-range pulse fits below 2^18
	localparam int MAG_W      = 17;   // |angle| up to 32768
	localparam int FOLD_W     = 14;   // folded angle 0..9000
	localparam int COS_W      = 16;   // Q1.15 magnitude, 32768 allowed
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	// Parameter defaults
	localparam int DEF_COS_TABLE_DEPTH = 256;
	localparam int DEF_CAPTURE_WIDTH   = 32;

	// Register reset values
	localparam logic [CLK_W-1:0]    RST_CLOCK_HZ = CLK_W'(80000000);
	localparam logic [TILT_W-1:0]   RST_MAX_TILT = TILT_W'(2500);
	localparam logic [FACTOR_W-1:0] RST_FACTOR   = FACTOR_W'(58);

	// Arithmetic constants
	localparam int unsigned PULSE_SCALE = 10000000;
	localparam int unsigned PULSE_MIN   = 1150;
	localparam int unsigned PULSE_MAX   = 185000;
	localparam int unsigned RIGHT_ANGLE = 9000;
	localparam int unsigned HALF_TURN   = 18000;
	localparam int unsigned FULL_TURN   = 36000;
	localparam int unsigned COS_ONE     = 32768;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Taylor series denominators (2k-1)*2k for k = 1..8
	localparam logic [63:0] TAYLOR_DIV [8] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
	};

	// Register word indexes
	localparam logic [1:0] REG_CLOCK_HZ = 2'd0;
	localparam logic [1:0] REG_MAX_TILT = 2'd1;
	localparam logic [1:0] REG_FACTOR   = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_TILTED = 2'd2;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CCHK,
		ST_DIV_Q,
		ST_DIV_P,
		ST_QCHK,
		ST_DIV_D,
		ST_DIV_R,
		ST_DIV_T,
		ST_MUL1,
		ST_MUL2,
		ST_DONE
	} setr_state_t;

	// Q1.15 cosine of a Q30 angle via Taylor series through x^16, rounded.
	// Evaluated at elaboration only.
	function automatic logic [COS_W-1:0] cos_q15_entry(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        r;
		logic signed [63:0] sum;
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		sum  = signed'(term);
		for (int k = 1; k <= 8; k++) begin
			term = (term * x2) >> 30;
			term = term / TAYLOR_DIV[k-1];
			if (k[0])
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		if (sum < 0)
			sum = 64'sd0;
		r = (unsigned'(sum) + 64'd16384) >> 15;
		if (r > 64'(COS_ONE))
			r = 64'(COS_ONE);
		return r[COS_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/sonar_echo_tilt_ranger.sv
// Top level: echo pulse capture, bit-serial divider and tilt-corrected distance queries.
//
//  port group    | direction | handshake            | payload
//  --------------+-----------+----------------------+---------------------------------------
//  input items   | in        | in_valid / in_stall  | req_type, capture_time, echo_level,
//                |           |                      | roll_angle, pitch_angle
//  results       | out       | out_valid / out_stall| distance_mm, status, was_fresh
//  configuration | in/out    | APB write/read       | clock_hz, max_tilt, roundtrip_factor
//
// One item at a time. Every division runs on one shared restoring divider that makes
// one quotient bit per cycle. A capture edge is checked first; a valid falling edge
// then runs two divisions. A query that is out of range or tilted ends at its check,
// else it runs three divisions, then multiplies the cosines and the distance. Reset is
// asynchronous and needs no clearing pass. A finished result sits in the output register
// while the next item is taken; only a second result waits for out_stall.
`default_nettype none

module sonar_echo_tilt_ranger
	import setr_pkg::*;
#(
	parameter int COS_TABLE_DEPTH = DEF_COS_TABLE_DEPTH,
	parameter int CAPTURE_WIDTH   = DEF_CAPTURE_WIDTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// input items
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      req_type,
	input  wire logic [TIME_W-1:0]         capture_time,
	input  wire logic                      echo_level,
	input  wire logic signed [ANGLE_W-1:0] roll_angle,
	input  wire logic signed [ANGLE_W-1:0] pitch_angle,
	// results
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [DIST_W-1:0]              distance_mm,
	output logic [STATUS_W-1:0]            status,
	output logic                           was_fresh,
	// configuration
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [APB_AW-1:0]         paddr,
	input  wire logic [APB_DW-1:0]         pwdata,
	output logic [APB_DW-1:0]              prdata,
	output logic                           pready
);

	localparam int IDXP_W = $clog2(RIGHT_ANGLE * COS_TABLE_DEPTH + 1);
	localparam int DVD_W  = (IDXP_W > CLK_W) ? IDXP_W : CLK_W;
	localparam int DVS_W  = CLK_W;
	localparam int CNT_W  = $clog2(DVD_W + 1);
	localparam int IDX_W  = $clog2(COS_TABLE_DEPTH + 1);
	localparam int CMP_W  = (CAPTURE_WIDTH > CLK_W) ? CAPTURE_WIDTH : CLK_W;
	localparam int PROD_W = 2 * COS_W - 1;
	localparam int DV_W   = PULSE_W + PROD_W;

	// Control state
	setr_state_t              state_q, state_d;
	logic [CNT_W-1:0]         cnt_q;
	logic [CLK_W-1:0]         clock_hz_q;
	logic [TILT_W-1:0]        max_tilt_q;
	logic [FACTOR_W-1:0]      factor_q;
	logic [CAPTURE_WIDTH-1:0] prev_capture_q;
	logic                     prev_level_q;
	logic                     pulse_ok_q;
	logic                     fresh_q;
	logic                     out_valid_q;

	// Datapath registers
	logic [PULSE_W-1:0]       pulse_q;
	logic [CAPTURE_WIDTH-1:0] diff_q;
	logic                     edge_q;
	logic [MAG_W-1:0]         roll_mag_q;
	logic [MAG_W-1:0]         pitch_mag_q;
	logic                     fresh_snap_q;
	logic [STATUS_W-1:0]      status_q;
	logic [PULSE_W-1:0]       d_q;
	logic                     neg_r_q;
	logic                     neg_p_q;
	logic [COS_W-1:0]         cos_r_q;
	logic [COS_W-1:0]         cos_p_q;
	logic [PROD_W-1:0]        prod_q;
	logic                     pos_q;
	logic [DV_W-1:0]          dv_q;
	logic [DIST_W-1:0]        dist_out_q;
	logic [STATUS_W-1:0]      status_out_q;
	logic                     fresh_out_q;

	// Divider registers
	logic [DVD_W-1:0]         dvd_q;
	logic [DVS_W-1:0]         dvs_q;
	logic [DVS_W-1:0]         rem_q;

	// Combinational
	logic                     in_acc;
	logic                     out_free;
	logic                     cfg_wr;
	logic                     div_done;
	logic                     div_start;
	logic [DVD_W-1:0]         div_dvd;
	logic [DVS_W-1:0]         div_dvs;
	logic [DVS_W:0]           div_trial;
	logic [DVS_W:0]           div_sub;
	logic                     div_ge;
	logic [CAPTURE_WIDTH-1:0] curr;
	logic                     long_pulse;
	logic                     tilt_bad;
	logic [FACTOR_W-1:0]      factor_eff;
	logic [FOLD_W:0]          fold_r;
	logic [FOLD_W:0]          fold_p;
	logic [IDX_W-1:0]         cos_idx;
	logic [COS_W-1:0]         cos_rd;
	logic [DV_W-PROD_W:0]     dist_raw;
	logic [DIST_W-1:0]        dist_sat;
	logic [COS_W-1:0]         cos_rom [COS_TABLE_DEPTH+1];

	// Two's complement magnitude of a 16-bit angle
	function automatic logic [MAG_W-1:0] abs_angle(input logic [ANGLE_W-1:0] a);
		if (a[ANGLE_W-1])
			return MAG_W'(1 << ANGLE_W) - MAG_W'(a);
		return MAG_W'(a);
	endfunction

	// Fold |angle| into 0..90 deg; MSB of the result flags a negative cosine
	function automatic logic [FOLD_W:0] fold_angle(input logic [MAG_W-1:0] m);
		logic [MAG_W-1:0] m1;
		logic [MAG_W-1:0] m2;
		logic             neg;
		m1  = (m > MAG_W'(HALF_TURN)) ? MAG_W'(FULL_TURN) - m : m;
		neg = (m1 > MAG_W'(RIGHT_ANGLE));
		m2  = neg ? MAG_W'(HALF_TURN) - m1 : m1;
		return {neg, m2[FOLD_W-1:0]};
	endfunction

	// Cosine table, built at elaboration
	for (genvar g = 0; g <= COS_TABLE_DEPTH; g++) begin : gen_cos_rom
		localparam logic [63:0] XQ30 = 64'(g) * HALF_PI_Q30 / 64'(COS_TABLE_DEPTH);
		assign cos_rom[g] = cos_q15_entry(XQ30);
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign cfg_wr      = psel && penable && pwrite && pready;
	assign pready      = 1'b1;
	assign out_valid   = out_valid_q;
	assign distance_mm = dist_out_q;
	assign status      = status_out_q;
	assign was_fresh   = fresh_out_q;

	assign curr       = capture_time[CAPTURE_WIDTH-1:0];
	assign long_pulse = (CMP_W'(diff_q) > CMP_W'(clock_hz_q));
	assign tilt_bad   = (roll_mag_q > MAG_W'(max_tilt_q)) || (pitch_mag_q > MAG_W'(max_tilt_q));
	assign factor_eff = (factor_q == '0) ? FACTOR_W'(1) : factor_q;
	assign fold_r     = fold_angle(roll_mag_q);
	assign fold_p     = fold_angle(pitch_mag_q);

	// Table lookup from a finished index division, clamped to the last entry
	assign cos_idx = (dvd_q > DVD_W'(COS_TABLE_DEPTH)) ? IDX_W'(COS_TABLE_DEPTH)
	                                                  : dvd_q[IDX_W-1:0];
	assign cos_rd  = cos_rom[cos_idx];

	// Final scaling and saturation
	assign dist_raw = dv_q[DV_W-1:30];
	assign dist_sat = (dist_raw > (DV_W-PROD_W+1)'((1 << DIST_W) - 1)) ? '1
	                                                                   : dist_raw[DIST_W-1:0];

	// Divider step: one quotient bit per cycle
	assign div_done  = (cnt_q == '0);
	assign div_trial = {rem_q, dvd_q[DVD_W-1]};
	assign div_sub   = div_trial - {1'b0, dvs_q};
	assign div_ge    = (div_trial >= {1'b0, dvs_q});

	// Config read back
	always_comb begin
		unique case (paddr[3:2])
			REG_CLOCK_HZ: prdata = APB_DW'(clock_hz_q);
			REG_MAX_TILT: prdata = APB_DW'(max_tilt_q);
			REG_FACTOR:   prdata = APB_DW'(factor_q);
			default:      prdata = '0;
		endcase
	end

	// Sequencer: next state and divider launches
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc)
					state_d = req_type ? ST_QCHK : ST_CCHK;
			end
			ST_CCHK: begin
				if (!edge_q || long_pulse) begin
					state_d = ST_IDLE;
				end else begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(clock_hz_q);
					div_dvs   = DVS_W'(diff_q);
					state_d   = ST_DIV_Q;
				end
			end
			ST_DIV_Q: begin
				if (div_done) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(PULSE_SCALE);
					div_dvs   = DVS_W'(dvd_q);
					state_d   = ST_DIV_P;
				end
			end
			ST_DIV_P: begin
				if (div_done)
					state_d = ST_IDLE;
			end
			ST_QCHK: begin
				if (!pulse_ok_q || tilt_bad) begin
					state_d = ST_DONE;
				end else begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(pulse_q);
					div_dvs   = DVS_W'(factor_eff);
					state_d   = ST_DIV_D;
				end
			end
			ST_DIV_D: begin
				if (div_done) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(fold_r[FOLD_W-1:0]) * DVD_W'(COS_TABLE_DEPTH);
					div_dvs   = DVS_W'(RIGHT_ANGLE);
					state_d   = ST_DIV_R;
				end
			end
			ST_DIV_R: begin
				if (div_done) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(fold_p[FOLD_W-1:0]) * DVD_W'(COS_TABLE_DEPTH);
					div_dvs   = DVS_W'(RIGHT_ANGLE);
					state_d   = ST_DIV_T;
				end
			end
			ST_DIV_T: begin
				if (div_done)
					state_d = ST_MUL1;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: config, edge tracking, flags, divider count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			clock_hz_q     <= RST_CLOCK_HZ;
			max_tilt_q     <= RST_MAX_TILT;
			factor_q       <= RST_FACTOR;
			prev_capture_q <= '0;
			prev_level_q   <= 1'b0;
			pulse_ok_q     <= 1'b0;
			fresh_q        <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			// register writes
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_CLOCK_HZ: clock_hz_q <= pwdata[CLK_W-1:0];
					REG_MAX_TILT: max_tilt_q <= pwdata[TILT_W-1:0];
					REG_FACTOR:   factor_q   <= pwdata[FACTOR_W-1:0];
					default:      ;
				endcase
			end

			// divider bit counter
			if (div_start)
				cnt_q <= CNT_W'(DVD_W);
			else if (!div_done)
				cnt_q <= cnt_q - CNT_W'(1);

			// item acceptance
			if (in_acc) begin
				if (req_type) begin
					fresh_q <= 1'b0;
				end else begin
					prev_capture_q <= curr;
					prev_level_q   <= echo_level;
				end
			end

			// overlong pulse: marks out of range
			if (state_q == ST_CCHK && edge_q && long_pulse) begin
				pulse_ok_q <= 1'b0;
				fresh_q    <= 1'b1;
			end

			// new pulse length ready
			if (state_q == ST_DIV_P && div_done) begin
				pulse_ok_q <= (dvd_q >= DVD_W'(PULSE_MIN)) && (dvd_q <= DVD_W'(PULSE_MAX));
				fresh_q    <= 1'b1;
			end

			// output register: a new result replaces one leaving in the same cycle
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// divider
		if (div_start) begin
			dvd_q <= div_dvd;
			dvs_q <= div_dvs;
			rem_q <= '0;
		end else if (!div_done) begin
			rem_q <= div_ge ? div_sub[DVS_W-1:0] : div_trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], div_ge};
		end

		// capture edge check and query operands
		if (in_acc) begin
			edge_q       <= prev_level_q && !echo_level && (curr > prev_capture_q);
			diff_q       <= curr - prev_capture_q;
			roll_mag_q   <= abs_angle(roll_angle);
			pitch_mag_q  <= abs_angle(pitch_angle);
			fresh_snap_q <= fresh_q;
		end

		if (state_q == ST_DIV_P && div_done)
			pulse_q <= dvd_q[PULSE_W-1:0];

		// range check first, then tilt
		if (state_q == ST_QCHK) begin
			if (!pulse_ok_q)
				status_q <= STATUS_RANGE;
			else if (tilt_bad)
				status_q <= STATUS_TILTED;
			else
				status_q <= STATUS_OK;
		end

		if (state_q == ST_DIV_D && div_done) begin
			d_q     <= dvd_q[PULSE_W-1:0];
			neg_r_q <= fold_r[FOLD_W];
		end

		if (state_q == ST_DIV_R && div_done) begin
			cos_r_q <= cos_rd;
			neg_p_q <= fold_p[FOLD_W];
		end

		if (state_q == ST_DIV_T && div_done)
			cos_p_q <= cos_rd;

		// cos(roll) * cos(pitch) as magnitude and sign
		if (state_q == ST_MUL1) begin
			prod_q <= PROD_W'(cos_r_q) * PROD_W'(cos_p_q);
			pos_q  <= (neg_r_q == neg_p_q);
		end

		if (state_q == ST_MUL2)
			dv_q <= DV_W'(d_q) * DV_W'(prod_q);

		// result transaction
		if (state_q == ST_DONE && out_free) begin
			dist_out_q   <= (status_q == STATUS_OK && pos_q) ? dist_sat : '0;
			status_out_q <= status_q;
			fresh_out_q  <= fresh_snap_q;
		end
	end

endmodule

`default_nettype wire
